@@ hdl/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types, event codes and register indexes of the touch event mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

   localparam int RAW_W     = 32;
   localparam int SIZE_W    = 12;
   localparam int POINT_W   = 11;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_STEPS = POINT_W;
   localparam int STEP_W    = 4;

   // event types and codes
   localparam logic [4:0] EV_SYNC      = 5'd0;
   localparam logic [4:0] EV_KEY       = 5'd1;
   localparam logic [4:0] EV_ABS       = 5'd3;
   localparam logic [9:0] ABS_X        = 10'd0;
   localparam logic [9:0] ABS_Y        = 10'd1;
   localparam logic [9:0] ABS_PRESS    = 10'd24;
   localparam logic [9:0] KEY_TOUCH    = 10'd330;
   localparam logic [9:0] SYNC_MARK    = 10'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MAX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic [RAW_W-1:0]  RAW_MAX_RESET       = 32'd4095;
   localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 12'd480;
   localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 12'd320;
   localparam logic [SIZE_W-1:0] SCREEN_LIMIT        = 12'd2048;

   typedef struct packed {
      logic [4:0]              event_type;
      logic [9:0]              event_code;
      logic signed [RAW_W-1:0] event_value;
   } req_type;

   typedef struct packed {
      logic               is_pressed;
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
   } rsp_type;

   typedef struct packed {
      logic signed [RAW_W-1:0] x_raw_min;
      logic signed [RAW_W-1:0] x_raw_max;
      logic signed [RAW_W-1:0] y_raw_min;
      logic signed [RAW_W-1:0] y_raw_max;
      logic [SIZE_W-1:0]       screen_width;
      logic [SIZE_W-1:0]       screen_height;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PREP,
      OP_MUL,
      OP_STEP
   } unit_op_type;

   typedef struct packed {
      unit_op_type             op;
      logic signed [RAW_W-1:0] raw;
      logic signed [RAW_W-1:0] lo;
      logic signed [RAW_W-1:0] hi;
      logic [SIZE_W-1:0]       size;
   } unit_cmd_type;

   // size 0 acts as 1, sizes above the limit act as the limit
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = {{(SIZE_W-1){1'b0}}, 1'b1};
      end else if (s > SCREEN_LIMIT) begin
         r = SCREEN_LIMIT;
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/tsm_scale_unit.sv @@
// ----------------------------------------------------------------------------
// tsm_scale_unit
// Shared scaling datapath: offset and span subtract, one 32x12 multiply, and a
// restoring divider that retires one quotient bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsm_scale_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tsm_pkg::unit_cmd_type         cmd,
   output logic [tsm_pkg::POINT_W-1:0]        result
);
   import tsm_pkg::*;

   logic [RAW_W:0]       diff_ff, diff_in;
   logic [RAW_W:0]       span_ff, span_in;
   logic                 empty_ff, empty_in;
   logic                 under_ff, under_in;
   logic                 over_ff, over_in;
   logic [RAW_W-1:0]     rem_ff, rem_in;
   logic [POINT_W-1:0]   num_lo_ff, num_lo_in;
   logic [POINT_W-1:0]   quot_ff, quot_in;

   logic [RAW_W+SIZE_W-1:0] prod;
   logic [RAW_W+1:0]        trial;
   logic [SIZE_W-1:0]       size_m1;

   assign prod    = {{SIZE_W{1'b0}}, diff_ff[RAW_W-1:0]} * {{RAW_W{1'b0}}, cmd.size};
   assign trial   = {1'b0, rem_ff, num_lo_ff[POINT_W-1]} - {2'b00, span_ff[RAW_W-1:0]};
   assign size_m1 = cmd.size - {{(SIZE_W-1){1'b0}}, 1'b1};

   always_comb begin
      diff_in   = diff_ff;
      span_in   = span_ff;
      empty_in  = empty_ff;
      under_in  = under_ff;
      over_in   = over_ff;
      rem_in    = rem_ff;
      num_lo_in = num_lo_ff;
      quot_in   = quot_ff;
      case (cmd.op)
         OP_PREP: begin
            diff_in  = {cmd.raw[RAW_W-1], cmd.raw} - {cmd.lo[RAW_W-1], cmd.lo};
            span_in  = {cmd.hi[RAW_W-1], cmd.hi} - {cmd.lo[RAW_W-1], cmd.lo};
            empty_in = (cmd.hi <= cmd.lo);
            under_in = diff_in[RAW_W];
            over_in  = ($signed(diff_in) >= $signed(span_in));
            quot_in  = '0;
         end
         OP_MUL: begin
            // quotient is below 2^11, so the top part starts below the span
            rem_in    = prod[RAW_W+POINT_W-1:POINT_W];
            num_lo_in = prod[POINT_W-1:0];
         end
         OP_STEP: begin
            if (!trial[RAW_W+1]) begin
               rem_in = trial[RAW_W-1:0];
            end else begin
               rem_in = {rem_ff[RAW_W-2:0], num_lo_ff[POINT_W-1]};
            end
            num_lo_in = {num_lo_ff[POINT_W-2:0], 1'b0};
            quot_in   = {quot_ff[POINT_W-2:0], ~trial[RAW_W+1]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= 1'b0;
         under_ff <= 1'b0;
         over_ff  <= 1'b0;
      end else begin
         empty_ff <= empty_in;
         under_ff <= under_in;
         over_ff  <= over_in;
      end
      diff_ff   <= diff_in;
      span_ff   <= span_in;
      rem_ff    <= rem_in;
      num_lo_ff <= num_lo_in;
      quot_ff   <= quot_in;
   end

   always_comb begin
      if (empty_ff || under_ff) begin
         result = '0;
      end else if (over_ff) begin
         result = size_m1[POINT_W-1:0];
      end else begin
         result = quot_ff;
      end
   end

endmodule

`default_nettype wire

@@ hdl/tsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsm_ctrl
// Event decode, latest raw state, and the sequencer that runs both axes of a
// report through the shared scaling unit and loads the held point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire tsm_pkg::req_type      req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output tsm_pkg::rsp_type           rsp_data,
   input  wire tsm_pkg::cfg_type      cfg,
   output tsm_pkg::unit_cmd_type      unit_cmd,
   input  wire logic [tsm_pkg::POINT_W-1:0] unit_result
);
   import tsm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PREP = 6'b000010,
      S_MUL  = 6'b000100,
      S_DIV  = 6'b001000,
      S_AXIS = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic                  axis_ff, axis_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [RAW_W-1:0]      raw_x_ff, raw_x_in;
   logic [RAW_W-1:0]      raw_y_ff, raw_y_in;
   logic                  pend_ff, pend_in;
   logic                  held_pressed_ff, held_pressed_in;
   logic [POINT_W-1:0]    held_x_ff, held_x_in;
   logic [POINT_W-1:0]    held_y_ff, held_y_in;
   logic [POINT_W-1:0]    sx_ff, sx_in;
   logic [POINT_W-1:0]    sy_ff, sy_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [SIZE_W-1:0]     width_eff;
   logic [SIZE_W-1:0]     height_eff;
   logic [SIZE_W-1:0]     height_m1;
   logic                  accept;
   logic                  val_nonzero;

   assign width_eff   = eff_size(cfg.screen_width);
   assign height_eff  = eff_size(cfg.screen_height);
   assign height_m1   = height_eff - {{(SIZE_W-1){1'b0}}, 1'b1};
   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign val_nonzero = (req_data.event_value != '0);

   // first pass maps raw y to screen x, second maps raw x to screen y
   always_comb begin
      unit_cmd.op = OP_NONE;
      case (state_ff)
         S_PREP:  unit_cmd.op = OP_PREP;
         S_MUL:   unit_cmd.op = OP_MUL;
         S_DIV:   unit_cmd.op = OP_STEP;
         default: unit_cmd.op = OP_NONE;
      endcase
      if (axis_ff) begin
         unit_cmd.raw  = raw_x_ff;
         unit_cmd.lo   = cfg.x_raw_min;
         unit_cmd.hi   = cfg.x_raw_max;
         unit_cmd.size = height_eff;
      end else begin
         unit_cmd.raw  = raw_y_ff;
         unit_cmd.lo   = cfg.y_raw_min;
         unit_cmd.hi   = cfg.y_raw_max;
         unit_cmd.size = width_eff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      axis_in         = axis_ff;
      step_in         = step_ff;
      raw_x_in        = raw_x_ff;
      raw_y_in        = raw_y_ff;
      pend_in         = pend_ff;
      held_pressed_in = held_pressed_ff;
      held_x_in       = held_x_ff;
      held_y_in       = held_y_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.event_type == EV_ABS) begin
                  if (req_data.event_code == ABS_X) begin
                     raw_x_in = req_data.event_value;
                  end else if (req_data.event_code == ABS_Y) begin
                     raw_y_in = req_data.event_value;
                  end else if (req_data.event_code == ABS_PRESS) begin
                     pend_in = !req_data.event_value[RAW_W-1] && val_nonzero;
                  end
               end else if (req_data.event_type == EV_KEY
                            && req_data.event_code == KEY_TOUCH) begin
                  pend_in = val_nonzero;
               end else if (req_data.event_type == EV_SYNC
                            && req_data.event_code == SYNC_MARK) begin
                  axis_in  = 1'b0;
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            step_in = step_ff + {{(STEP_W-1){1'b0}}, 1'b1};
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            if (axis_ff) begin
               sy_in    = height_m1[POINT_W-1:0] - unit_result;
               state_in = S_OUT;
            end else begin
               sx_in    = unit_result;
               axis_in  = 1'b1;
               state_in = S_PREP;
            end
         end
         S_OUT: begin
            // wait for the output slot before touching the held point
            if (!rsp_valid_ff || rsp_ready) begin
               held_pressed_in = pend_ff;
               if (pend_ff) begin
                  held_x_in = sx_ff;
                  held_y_in = sy_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         axis_ff         <= 1'b0;
         step_ff         <= '0;
         raw_x_ff        <= '0;
         raw_y_ff        <= '0;
         pend_ff         <= 1'b0;
         held_pressed_ff <= 1'b0;
         held_x_ff       <= '0;
         held_y_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         axis_ff         <= axis_in;
         step_ff         <= step_in;
         raw_x_ff        <= raw_x_in;
         raw_y_ff        <= raw_y_in;
         pend_ff         <= pend_in;
         held_pressed_ff <= held_pressed_in;
         held_x_ff       <= held_x_in;
         held_y_ff       <= held_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.is_pressed = held_pressed_ff;
   assign rsp_data.point_x    = held_x_ff;
   assign rsp_data.point_y    = held_y_ff;

endmodule

`default_nettype wire

@@ hdl/touch_event_to_screen_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// touch_event_to_screen_mapper_unit
// Maps touch input events to held screen coordinates on each sync report.
// ----------------------------------------------------------------------------
// Axis, pressure and touch key requests are absorbed and give no response. A sync
// report request presents its response after both axes have been scaled and the
// response register is free: each axis makes one pass (offset and span, one
// multiply, 11 divider steps, result) through a single shared scaling unit, and
// the output state then loads the response. The block does not accept requests
// during that time, so the next request is taken only once the response is loaded.
// The response register holds the last result until taken, and a new report
// waits in its output state until the previous one has left. Configuration
// writes take effect on the next clock and must be made while no report is in
// progress.
`timescale 1ns / 1ps
`default_nettype none

module touch_event_to_screen_mapper_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire tsm_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output tsm_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [tsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tsm_pkg::RAW_W-1:0]         csr_wdata
);
   import tsm_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   unit_cmd_type          unit_cmd;
   logic [POINT_W-1:0]    unit_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_X_RAW_MIN:     cfg_in.x_raw_min     = csr_wdata;
            CSR_X_RAW_MAX:     cfg_in.x_raw_max     = csr_wdata;
            CSR_Y_RAW_MIN:     cfg_in.y_raw_min     = csr_wdata;
            CSR_Y_RAW_MAX:     cfg_in.y_raw_max     = csr_wdata;
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_raw_min     <= '0;
         cfg_ff.x_raw_max     <= RAW_MAX_RESET;
         cfg_ff.y_raw_min     <= '0;
         cfg_ff.y_raw_max     <= RAW_MAX_RESET;
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cfg         (cfg_ff),
      .unit_cmd    (unit_cmd),
      .unit_result (unit_result)
   );

   tsm_scale_unit u_scale (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .result (unit_result)
   );

endmodule

`default_nettype wire

@@ hdl/tsm_checker.sv @@
// ----------------------------------------------------------------------------
// tsm_checker
// Port level checks of the touch event mapper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsm_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire tsm_pkg::req_type      req_data,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire tsm_pkg::rsp_type      rsp_data
);
   import tsm_pkg::*;

   logic sync_accept;

   assign sync_accept = req_valid && req_ready
                        && req_data.event_type == EV_SYNC
                        && req_data.event_code == SYNC_MARK;

   // no response is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a report keeps the block busy for its scaling passes
   a_sync_busy: assert property (@(posedge clock) disable iff (reset)
      sync_accept |=> !req_ready)
      else $error("request accepted during report scaling");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before accepted");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind touch_event_to_screen_mapper_unit tsm_checker u_tsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the touch event to screen mapper unit. Drives axis, pressure,
// touch key, sync and unknown requests over several register settings, keeps
// its own copy of the mapping state, and checks every report field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import tsm_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int REPORT_LATENCY = 30;
   localparam int RANDOM_EVENTS  = 1850;
   localparam int SETTINGS_COUNT = 9;
   localparam int CYCLE_LIMIT    = 600000;

   typedef struct {
      req_type ev;
      bit      wait_drain;
   } queued_touch_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RAW_W-1:0]     csr_wdata = '0;

   touch_event_to_screen_mapper_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mapping state mirrored from the block, reset values
   logic signed [RAW_W-1:0] x_min_cfg = 0;
   logic signed [RAW_W-1:0] x_max_cfg = 4095;
   logic signed [RAW_W-1:0] y_min_cfg = 0;
   logic signed [RAW_W-1:0] y_max_cfg = 4095;
   logic [SIZE_W-1:0]       width_cfg = 12'd480;
   logic [SIZE_W-1:0]       height_cfg = 12'd320;
   logic signed [RAW_W-1:0] raw_x = 0;
   logic signed [RAW_W-1:0] raw_y = 0;
   logic                    touch_pending = 1'b0;
   logic [POINT_W-1:0]      held_x = '0;
   logic [POINT_W-1:0]      held_y = '0;

   queued_touch_type touch_requests_q[$];
   queued_touch_type next_request;
   rsp_type          expected_reports_q[$];

   int send_idle_pct = 18;
   int recv_idle_pct = 69;
   int fail_count = 0;
   int requests_sent = 0;
   int touch_inputs_queued = 0;
   int reports_checked = 0;
   int pressed_reports = 0;
   int cycle_count = 0;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int unsigned effective_size(logic [SIZE_W-1:0] s);
      if (s == 0) return 1;
      if (s > 2048) return 2048;
      return s;
   endfunction

   // exact scaling with truncating division, clamped to the screen
   function automatic int unsigned scale_raw(logic signed [RAW_W-1:0] raw,
                                             logic signed [RAW_W-1:0] lo,
                                             logic signed [RAW_W-1:0] hi,
                                             int unsigned sz);
      longint span;
      longint num;
      longint quot;
      if (hi <= lo) return 0;
      span = longint'(hi) - longint'(lo);
      num  = (longint'(raw) - longint'(lo)) * longint'(sz);
      quot = num / span;
      if (quot < 0) return 0;
      if (quot >= longint'(sz)) return sz - 1;
      return int'(quot);
   endfunction

   function automatic void track_touch_event(req_type ev);
      logic signed [RAW_W-1:0] value;
      int unsigned             w;
      int unsigned             h;
      int unsigned             sx;
      int unsigned             sy;
      rsp_type                 rsp;
      value = ev.event_value;
      case (ev.event_type)
         EV_ABS: begin
            if (ev.event_code == ABS_X) begin
               raw_x = value;
            end else if (ev.event_code == ABS_Y) begin
               raw_y = value;
            end else if (ev.event_code == ABS_PRESS) begin
               touch_pending = (value > 0);
            end
         end
         EV_KEY: begin
            if (ev.event_code == KEY_TOUCH) touch_pending = (value != 0);
         end
         EV_SYNC: begin
            if (ev.event_code == SYNC_MARK) begin
               w  = effective_size(width_cfg);
               h  = effective_size(height_cfg);
               sx = scale_raw(raw_y, y_min_cfg, y_max_cfg, w);
               // screen y runs against raw x
               sy = (h - 1) - scale_raw(raw_x, x_min_cfg, x_max_cfg, h);
               if (touch_pending) begin
                  held_x = sx[POINT_W-1:0];
                  held_y = sy[POINT_W-1:0];
               end
               rsp.is_pressed = touch_pending;
               rsp.point_x    = held_x;
               rsp.point_y    = held_y;
               expected_reports_q.push_back(rsp);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void push_event(logic [4:0] ev_type, logic [9:0] ev_code,
                                      logic [RAW_W-1:0] ev_value, bit drain = 1'b0);
      queued_touch_type item;
      item.ev.event_type  = ev_type;
      item.ev.event_code  = ev_code;
      item.ev.event_value = ev_value;
      item.wait_drain     = drain;
      touch_requests_q.push_back(item);
      if ((ev_type == EV_ABS && (ev_code == ABS_X || ev_code == ABS_Y ||
                                 ev_code == ABS_PRESS)) ||
          (ev_type == EV_KEY && ev_code == KEY_TOUCH) ||
          (ev_type == EV_SYNC && ev_code == SYNC_MARK)) begin
         touch_inputs_queued++;
      end
   endfunction

   // raw position: mostly inside the range, some at its edges, some anywhere
   function automatic logic [RAW_W-1:0] pick_raw(logic signed [RAW_W-1:0] lo,
                                                 logic signed [RAW_W-1:0] hi);
      int                r;
      longint            span;
      longint unsigned   pick;
      longint            v;
      r = $urandom_range(99);
      if (r < 20 || hi <= lo) return $urandom;
      if (r < 30) begin
         case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return lo - 1;
            default: return hi + 1;
         endcase
      end
      span = longint'(hi) - longint'(lo) + 1;
      pick = {$urandom, $urandom};
      v = longint'(lo) + longint'(pick % longint'(span));
      return v[RAW_W-1:0];
   endfunction

   function automatic logic [RAW_W-1:0] random_raw_limit(logic signed [RAW_W-1:0] lo);
      longint v;
      if ($urandom_range(1) == 0) return $urandom;
      v = longint'(lo) + longint'($urandom_range(60000, 1));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      return v[RAW_W-1:0];
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [RAW_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_X_RAW_MIN:     x_min_cfg  = value;
         CSR_X_RAW_MAX:     x_max_cfg  = value;
         CSR_Y_RAW_MIN:     y_min_cfg  = value;
         CSR_Y_RAW_MAX:     y_max_cfg  = value;
         CSR_SCREEN_WIDTH:  width_cfg  = value[SIZE_W-1:0];
         CSR_SCREEN_HEIGHT: height_cfg = value[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_setting(input logic [RAW_W-1:0] x_lo, input logic [RAW_W-1:0] x_hi,
                                input logic [RAW_W-1:0] y_lo, input logic [RAW_W-1:0] y_hi,
                                input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      logic [RAW_W-1:0] word;
      write_csr(CSR_X_RAW_MIN, x_lo);
      write_csr(CSR_X_RAW_MAX, x_hi);
      write_csr(CSR_Y_RAW_MIN, y_lo);
      write_csr(CSR_Y_RAW_MAX, y_hi);
      // junk in the unused upper bits of the size registers
      word = $urandom;
      word[SIZE_W-1:0] = w;
      write_csr(CSR_SCREEN_WIDTH, word);
      word = $urandom;
      word[SIZE_W-1:0] = h;
      write_csr(CSR_SCREEN_HEIGHT, word);
   endtask

   // axis requests give no report, so give the block time after the last report
   task automatic wait_for_idle();
      do @(negedge clock);
      while (touch_requests_q.size() != 0 || req_valid || expected_reports_q.size() != 0);
      repeat (REPORT_LATENCY) @(posedge clock);
   endtask

   // request driver, predicts on every accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_touch_event(req_data);
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (touch_requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(touch_requests_q[0].wait_drain && expected_reports_q.size() != 0)) begin
               next_request = touch_requests_q.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_request.ev;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // report monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports_q.size() == 0) begin
               $error("unexpected report: is_pressed %0d point_x %0d point_y %0d",
                      rsp_data.is_pressed, rsp_data.point_x, rsp_data.point_y);
               fail_count++;
            end else begin
               if (rsp_data.is_pressed !== expected_reports_q[0].is_pressed) begin
                  $error("is_pressed: expected %0d, got %0d",
                         expected_reports_q[0].is_pressed, rsp_data.is_pressed);
                  fail_count++;
               end
               if (rsp_data.point_x !== expected_reports_q[0].point_x) begin
                  $error("point_x: expected %0d, got %0d",
                         expected_reports_q[0].point_x, rsp_data.point_x);
                  fail_count++;
               end
               if (rsp_data.point_y !== expected_reports_q[0].point_y) begin
                  $error("point_y: expected %0d, got %0d",
                         expected_reports_q[0].point_y, rsp_data.point_y);
                  fail_count++;
               end
               if (expected_reports_q[0].is_pressed) pressed_reports++;
               void'(expected_reports_q.pop_front());
               reports_checked++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int               target;
      int               r;
      logic [4:0]       ev_type;
      logic [9:0]       ev_code;
      logic [RAW_W-1:0] x_lo;
      logic [RAW_W-1:0] y_lo;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      bit               press_first;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset setting
      push_event(EV_SYNC, SYNC_MARK, 0);
      push_event(EV_ABS, ABS_X, 0);
      push_event(EV_ABS, ABS_Y, 4095);
      push_event(EV_ABS, ABS_PRESS, 1);
      push_event(EV_SYNC, SYNC_MARK, 0, 1'b1);
      push_event(EV_ABS, ABS_X, 4095);
      push_event(EV_ABS, ABS_Y, 0);
      push_event(EV_KEY, KEY_TOUCH, 1);
      push_event(EV_SYNC, SYNC_MARK, 0);
      // positions outside the raw range
      push_event(EV_ABS, ABS_X, -5);
      push_event(EV_ABS, ABS_Y, 5000);
      push_event(EV_SYNC, SYNC_MARK, 0);
      // released: held point repeats
      push_event(EV_ABS, ABS_PRESS, 0);
      push_event(EV_SYNC, SYNC_MARK, 0);
      // nonzero key presses, negative pressure releases
      push_event(EV_KEY, KEY_TOUCH, 32'hFFFF_FFFF);
      push_event(EV_ABS, ABS_PRESS, -3);
      push_event(EV_SYNC, SYNC_MARK, 0);
      // unknown types and codes are dropped
      push_event(5'd2, SYNC_MARK, 32'h1234_5678);
      push_event(EV_SYNC, 10'd1, 0);
      push_event(EV_KEY, 10'd0, 1);
      push_event(EV_ABS, 10'd2, 7);
      push_event(5'd31, 10'd1023, 32'hFFFF_FFFF);
      push_event(EV_ABS, ABS_X, 32'h7FFF_FFFF);
      push_event(EV_ABS, ABS_Y, 32'h8000_0000);
      push_event(EV_KEY, KEY_TOUCH, 1);
      push_event(EV_SYNC, SYNC_MARK, 0);
      wait_for_idle();

      for (int setting = 0; setting < SETTINGS_COUNT; setting++) begin
         if (setting == 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 18;
         end else if (setting == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (setting)
            0: write_setting(0, 4095, 0, 4095, 12'd480, 12'd320);
            1: write_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             12'd2048, 12'd2048);
            // empty ranges on both axes, one pixel screens
            2: write_setting(4095, 0, 100, 100, 12'd1, 12'd1);
            // out of range sizes act as one and as the limit
            3: write_setting(200, 3900, 150, 3850, 12'd0, 12'd4095);
            4: write_setting(-1000, 1000, 0, 1, 12'd2049, 12'd2047);
            default: begin
               x_lo = $urandom;
               y_lo = $urandom;
               w = ($urandom_range(4) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(2048, 1));
               h = ($urandom_range(4) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(2048, 1));
               write_setting(x_lo, random_raw_limit(x_lo), y_lo, random_raw_limit(y_lo), w, h);
            end
         endcase

         target = touch_inputs_queued + RANDOM_EVENTS / SETTINGS_COUNT;
         while (touch_inputs_queued < target) begin
            if ($urandom_range(99) < 85) begin
               // well-formed touch report with random content
               press_first = $urandom_range(1);
               r = $urandom_range(99);
               if (press_first && r < 80) begin
                  if (r < 30)      push_event(EV_ABS, ABS_PRESS, $urandom_range(4095, 1));
                  else if (r < 42) push_event(EV_ABS, ABS_PRESS, 0);
                  else if (r < 48) push_event(EV_ABS, ABS_PRESS, $urandom);
                  else if (r < 68) push_event(EV_KEY, KEY_TOUCH, 1);
                  else if (r < 76) push_event(EV_KEY, KEY_TOUCH, 0);
                  else             push_event(EV_KEY, KEY_TOUCH, $urandom);
               end
               if ($urandom_range(99) < 85) push_event(EV_ABS, ABS_X, pick_raw(x_min_cfg, x_max_cfg));
               if ($urandom_range(99) < 85) push_event(EV_ABS, ABS_Y, pick_raw(y_min_cfg, y_max_cfg));
               if (!press_first && r < 80) begin
                  if (r < 30)      push_event(EV_ABS, ABS_PRESS, $urandom_range(4095, 1));
                  else if (r < 42) push_event(EV_ABS, ABS_PRESS, 0);
                  else if (r < 48) push_event(EV_ABS, ABS_PRESS, $urandom);
                  else if (r < 68) push_event(EV_KEY, KEY_TOUCH, 1);
                  else if (r < 76) push_event(EV_KEY, KEY_TOUCH, 0);
                  else             push_event(EV_KEY, KEY_TOUCH, $urandom);
               end
               push_event(EV_SYNC, SYNC_MARK, $urandom, $urandom_range(99) < 2);
            end else begin
               // noise, partly with known types and random codes
               ev_type = $urandom_range(31);
               ev_code = $urandom_range(1023);
               case ($urandom_range(3))
                  0: ev_type = EV_SYNC;
                  1: ev_type = EV_KEY;
                  2: ev_type = EV_ABS;
                  default: ;
               endcase
               push_event(ev_type, ev_code, $urandom);
            end
         end
         wait_for_idle();
      end

      $display("sent %0d requests under %0d register settings and three idle profiles",
               requests_sent, SETTINGS_COUNT + 1);
      $display("checked %0d reports, %0d of them pressed", reports_checked, pressed_reports);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
